// ===== src/vsc_pkg.sv =====
package vsc_pkg;

	typedef logic signed [14:0] temp_t;
	typedef logic [13:0] hum_t;
	typedef logic [1:0] cls_t;
	typedef logic [3:0] fail_t;
	typedef logic [2:0] reg_idx_t;

	localparam int CFG_W = 15;

	localparam cls_t CLS_SHORT = 2'd0;
	localparam cls_t CLS_MID   = 2'd1;
	localparam cls_t CLS_LONG  = 2'd2;

	localparam fail_t FAIL_MAX      = 4'd15;
	localparam fail_t FAIL_ALERT_AT = 4'd10;

	localparam logic ACT_READING = 1'b0;
	localparam logic ACT_QUERY   = 1'b1;

	localparam reg_idx_t REG_TARGET_TEMP = 3'd0;
	localparam reg_idx_t REG_TEMP_BAND   = 3'd1;
	localparam reg_idx_t REG_TARGET_HUM  = 3'd2;
	localparam reg_idx_t REG_HUM_BAND    = 3'd3;
	localparam reg_idx_t REG_BANDS_VALID = 3'd4;
	localparam reg_idx_t REG_STABLE      = 3'd5;
	localparam reg_idx_t REG_MODERATE    = 3'd6;

	localparam logic [14:0] STABLE_RESET   = 15'd30;
	localparam logic [14:0] MODERATE_RESET = 15'd100;

	localparam int MIN_SAMPLES = 2;

	typedef struct packed {
		logic  start;
		logic  push;
		temp_t sample;
	} stats_req_t;

	typedef struct packed {
		logic done;
		cls_t cls;
	} stats_rsp_t;

endpackage

// ===== src/volatility_sleep_classifier.sv =====
// channel  | handshake            | beat contents
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | action, temperature, humidity, sensor_ok
// out      | out_valid / out_ready| interval_class, band_alert, used_temperature,
//          |                      | used_humidity, failure_count, failure_alert
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One beat at a time: the time from accept to result grows with n, the filled
// window length, and is set by the window scan through one memory read port and the
// shared multiplier (six products after the scan); both are skipped when n < 2.
// in_ready returns once the result sits in the output register, so a stalled
// output holds at most one result. Reset is asynchronous, active low; the
// window needs no clearing pass since only filled entries are read.
module volatility_sleep_classifier #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  vsc_pkg::temp_t           temperature,
	input  vsc_pkg::hum_t            humidity,
	input  logic                     sensor_ok,
	output logic                     out_valid,
	input  logic                     out_ready,
	output vsc_pkg::cls_t            interval_class,
	output logic                     band_alert,
	output vsc_pkg::temp_t           used_temperature,
	output vsc_pkg::hum_t            used_humidity,
	output vsc_pkg::fail_t           failure_count,
	output logic                     failure_alert,
	input  logic                     cfg_we,
	input  vsc_pkg::reg_idx_t        cfg_index,
	input  logic [vsc_pkg::CFG_W-1:0] cfg_data
);
	import vsc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;
	temp_t              target_temp_q;
	logic [14:0]        temp_band_q;
	hum_t               target_hum_q;
	hum_t               hum_band_q;
	logic               bands_valid_q;
	logic [14:0]        stable_q;
	logic [14:0]        moderate_q;

	logic               act_q;
	temp_t              t_in_q;
	hum_t               h_in_q;
	logic               ok_q;

	temp_t              prev_t_q;
	hum_t               prev_h_q;
	fail_t              fail_q;
	logic               alert_q;
	cls_t               cls_q;
	logic               out_valid_q;
	cls_t               out_cls_q;
	logic               out_alert_q;
	temp_t              out_t_q;
	hum_t               out_h_q;
	fail_t              out_fail_q;

	logic               reading;
	temp_t              new_t;
	hum_t               new_h;
	fail_t              new_fail;
	logic signed [15:0] dt;
	logic [15:0]        dt_abs;
	logic signed [14:0] dh;
	logic [14:0]        dh_abs;
	logic               new_alert;
	logic               out_load;

	stats_req_t         req;
	stats_rsp_t         rsp;

	assign reading = (act_q == ACT_READING);
	assign new_t   = ok_q ? t_in_q : prev_t_q;
	assign new_h   = ok_q ? h_in_q : prev_h_q;

	always_comb begin
		new_fail = fail_q;
		if (ok_q) begin
			new_fail = '0;
		end else if (fail_q < FAIL_MAX) begin
			new_fail = fail_q + 4'd1;
		end
	end

	assign dt        = 16'(new_t) - 16'(target_temp_q);
	assign dt_abs    = dt[15] ? 16'(-dt) : 16'(dt);
	assign dh        = signed'(15'(new_h)) - signed'(15'(target_hum_q));
	assign dh_abs    = dh[14] ? 15'(-dh) : 15'(dh);
	assign new_alert = bands_valid_q &&
		((dt_abs > 16'(temp_band_q)) || (dh_abs > 15'(hum_band_q)));

	assign req.start  = (state_q == ST_UPD);
	assign req.push   = reading;
	assign req.sample = new_t;

	vsc_stats #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.stable_limit   (stable_q),
		.moderate_limit (moderate_q),
		.rsp            (rsp)
	);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp_q <= '0;
			temp_band_q   <= '0;
			target_hum_q  <= '0;
			hum_band_q    <= '0;
			bands_valid_q <= 1'b0;
			stable_q      <= STABLE_RESET;
			moderate_q    <= MODERATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_TEMP: target_temp_q <= signed'(cfg_data);
				REG_TEMP_BAND:   temp_band_q   <= cfg_data;
				REG_TARGET_HUM:  target_hum_q  <= cfg_data[13:0];
				REG_HUM_BAND:    hum_band_q    <= cfg_data[13:0];
				REG_BANDS_VALID: bands_valid_q <= cfg_data[0];
				REG_STABLE:      stable_q      <= cfg_data;
				REG_MODERATE:    moderate_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_t_q    <= '0;
			prev_h_q    <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (reading) begin
						prev_t_q <= new_t;
						prev_h_q <= new_h;
						fail_q   <= new_fail;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= action;
			t_in_q <= temperature;
			h_in_q <= humidity;
			ok_q   <= sensor_ok;
		end
		if (state_q == ST_UPD) begin
			alert_q <= reading && new_alert;
		end
		if (rsp.done) begin
			cls_q <= rsp.cls;
		end
		if (out_load) begin
			out_cls_q   <= cls_q;
			out_alert_q <= alert_q;
			out_t_q     <= prev_t_q;
			out_h_q     <= prev_h_q;
			out_fail_q  <= fail_q;
		end
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign interval_class   = out_cls_q;
	assign band_alert       = out_alert_q;
	assign used_temperature = out_t_q;
	assign used_humidity    = out_h_q;
	assign failure_count    = out_fail_q;
	assign failure_alert    = out_fail_q >= FAIL_ALERT_AT;

endmodule

// ===== src/vsc_stats.sv =====
module vsc_stats #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vsc_pkg::stats_req_t req,
	input  logic [14:0]        stable_limit,
	input  logic [14:0]        moderate_limit,
	output vsc_pkg::stats_rsp_t rsp
);
	import vsc_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int IW = $clog2(WINDOW_DEPTH);
	localparam int KW = $clog2(WINDOW_DEPTH + 2);
	localparam int SW = 15 + CW;
	localparam int QW = 29 + CW;
	localparam int AW = 16 + CW;
	localparam int BW = 30 + CW;
	localparam int PW = 32 + 2 * CW;

	localparam logic [IW-1:0] SLOT_LAST = IW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW_DEPTH);
	localparam logic [CW-1:0] FILL_MIN  = CW'(MIN_SAMPLES);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ACC  = 4'd1;
	localparam logic [3:0] ST_NQ   = 4'd2;
	localparam logic [3:0] ST_SS   = 4'd3;
	localparam logic [3:0] ST_NLS  = 4'd4;
	localparam logic [3:0] ST_SQS  = 4'd5;
	localparam logic [3:0] ST_NLM  = 4'd6;
	localparam logic [3:0] ST_SQM  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]              state_q;
	logic [IW-1:0]           slot_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           fill_next;
	logic [CW-1:0]           n_q;
	logic                    few_q;
	logic [KW-1:0]           cnt_q;
	logic                    rd_v_q;
	logic                    p_v_q;
	logic                    rd_en;
	logic                    wr_en;
	logic                    acc_last;
	temp_t                   rd_q;
	temp_t                   window_mem [WINDOW_DEPTH];
	logic signed [SW-1:0]    s_q;
	logic [QW-1:0]           q_q;
	logic signed [PW-1:0]    p_q;
	logic signed [PW-1:0]    spread_q;
	logic                    long_q;
	logic signed [AW-1:0]    mul_a;
	logic signed [BW-1:0]    mul_b;
	logic signed [AW+BW-1:0] prod;

	assign wr_en = (state_q == ST_IDLE) && req.start && req.push;

	always_comb begin
		fill_next = fill_q;
		if (req.push && (fill_q != FILL_FULL)) begin
			fill_next = fill_q + CW'(1);
		end
	end

	assign rd_en    = (state_q == ST_ACC) && (cnt_q < KW'(n_q));
	assign acc_last = (cnt_q == KW'(n_q) + KW'(1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ACC: begin
				mul_a = AW'(rd_q);
				mul_b = BW'(rd_q);
			end
			ST_NQ: begin
				mul_a = signed'(AW'(n_q));
				mul_b = signed'(BW'(q_q));
			end
			ST_SS: begin
				mul_a = AW'(s_q);
				mul_b = BW'(s_q);
			end
			ST_NLS: begin
				mul_a = signed'(AW'(n_q));
				mul_b = signed'(BW'(stable_limit));
			end
			ST_NLM: begin
				mul_a = signed'(AW'(n_q));
				mul_b = signed'(BW'(moderate_limit));
			end
			ST_SQS, ST_SQM: begin
				mul_a = AW'(p_q);
				mul_b = BW'(p_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			window_mem[slot_q] <= req.sample;
		end
		if (rd_en) begin
			rd_q <= window_mem[cnt_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
			rd_v_q  <= 1'b0;
			p_v_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						if (req.push) begin
							slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + IW'(1);
						end
						fill_q <= fill_next;
						cnt_q  <= '0;
						rd_v_q <= 1'b0;
						p_v_q  <= 1'b0;
						state_q <= (fill_next < FILL_MIN) ? ST_FIN : ST_ACC;
					end
				end
				ST_ACC: begin
					cnt_q  <= cnt_q + KW'(1);
					rd_v_q <= rd_en;
					p_v_q  <= rd_v_q;
					if (acc_last) begin
						state_q <= ST_NQ;
					end
				end
				ST_NQ:  state_q <= ST_SS;
				ST_SS:  state_q <= ST_NLS;
				ST_NLS: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_NLM;
				ST_NLM: state_q <= ST_SQM;
				ST_SQM: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					n_q   <= fill_next;
					few_q <= fill_next < FILL_MIN;
					s_q   <= '0;
					q_q   <= '0;
				end
			end
			ST_ACC: begin
				if (rd_v_q) begin
					s_q <= s_q + SW'(rd_q);
					p_q <= PW'(prod);
				end
				if (p_v_q) begin
					q_q <= q_q + QW'(p_q);
				end
			end
			ST_NQ: p_q <= PW'(prod);
			ST_SS: begin
				spread_q <= p_q;
				p_q      <= PW'(prod);
			end
			ST_NLS: begin
				spread_q <= spread_q - p_q;
				p_q      <= PW'(prod);
			end
			ST_SQS: p_q <= PW'(prod);
			ST_NLM: begin
				long_q <= spread_q < p_q;
				p_q    <= PW'(prod);
			end
			ST_SQM: p_q <= PW'(prod);
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp.done = (state_q == ST_FIN);
		priority if (few_q) begin
			rsp.cls = CLS_SHORT;
		end else if (long_q) begin
			rsp.cls = CLS_LONG;
		end else if (spread_q < p_q) begin
			rsp.cls = CLS_MID;
		end else begin
			rsp.cls = CLS_SHORT;
		end
	end

endmodule

// ===== src/vsc_checker.sv =====
module vsc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input vsc_pkg::cls_t             interval_class,
	input logic                      band_alert,
	input vsc_pkg::temp_t            used_temperature,
	input vsc_pkg::hum_t             used_humidity,
	input vsc_pkg::fail_t            failure_count,
	input logic                      failure_alert
);
	import vsc_pkg::*;

	// one beat in flight: no accept right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a beat is in flight");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (interval_class == CLS_SHORT || interval_class == CLS_MID ||
			interval_class == CLS_LONG))
		else $error("interval class out of range");

	a_fail_alert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (failure_alert == (failure_count >= FAIL_ALERT_AT)))
		else $error("failure alert does not match failure count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(interval_class) &&
			$stable(band_alert) && $stable(used_temperature) &&
			$stable(used_humidity) && $stable(failure_count))
		else $error("stalled output beat changed");

endmodule

bind volatility_sleep_classifier vsc_checker u_vsc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.interval_class   (interval_class),
	.band_alert       (band_alert),
	.used_temperature (used_temperature),
	.used_humidity    (used_humidity),
	.failure_count    (failure_count),
	.failure_alert    (failure_alert)
);
